// ===== rtl/core/lptc_pkg.sv =====
// lptc_pkg: shared widths, constants, CORDIC arctangent table and the
// controller-to-datapath command struct for lidar_polar_to_cartesian.
// No dependencies.
package lptc_pkg;

    // Range sample width and CORDIC iteration count
    localparam int RANGE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

    // Datapath widths
    localparam int ANGLE_W  = 32;
    localparam int CORDIC_W = 34;
    localparam int TRIG_W   = 16;
    localparam int COORD_W  = 17;
    localparam int PROD1_W  = RANGE_BITS + 1 + TRIG_W;
    localparam int PROD2_W  = PROD1_W + TRIG_W;

    // CORDIC constants (Q2.30 vectors, binary-angle z)
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = CORDIC_W'(64'sd652032874);
    localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = CORDIC_W'(64'sd1073741824);
    localparam logic signed [CORDIC_W-1:0] TRIG_HALF    = CORDIC_W'(64'sd16384);
    localparam logic signed [CORDIC_W-1:0] TRIG_MAX     = CORDIC_W'(64'sd32767);
    localparam logic signed [CORDIC_W-1:0] TRIG_MIN     = -CORDIC_W'(64'sd32768);
    localparam int TRIG_SHIFT = 15;

    // Coordinate rounding and limits
    localparam logic signed [PROD2_W-1:0] Z_HALF    = PROD2_W'(64'sd16384);
    localparam logic signed [PROD2_W-1:0] XY_HALF   = PROD2_W'(64'sd536870912);
    localparam logic signed [PROD2_W-1:0] COORD_MAX = PROD2_W'(64'sd65535);
    localparam int Z_SHIFT  = 15;
    localparam int XY_SHIFT = 30;

    // Configuration register map
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_START_AZIMUTH   = 2'd0;
    localparam logic [1:0] REG_AZIMUTH_STEP    = 2'd1;
    localparam logic [1:0] REG_ELEVATION_ANGLE = 2'd2;

    // Controller commands to the datapath
    typedef struct packed {
        logic              load;
        logic              rotate;
        logic              round;
        logic              mul1;
        logic              mul2;
        logic              write;
        logic [STEP_W-1:0] step;
    } ctrl_cmd_t;

    // atan(2^-i) in binary-angle units
    function automatic logic [ANGLE_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/lidar_polar_to_cartesian.sv =====
// lidar_polar_to_cartesian: top level; ties together config registers,
// controller and datapath. Depends on lptc_pkg, lptc_regs, lptc_ctrl, lptc_datapath.
//
// Converts one lidar scan layer from range samples to Cartesian points in
// centimetres. Each accepted item (range_cm, scan_end) yields exactly one
// point (pos_x, pos_y, pos_z, point_last). The azimuth of the first item
// after reset or after an item marked scan_end is start_azimuth; each later
// item adds azimuth_step (wrapping modulo one turn). All angles are 32-bit
// binary angles, 2^32 per turn. Two CORDIC lanes run side by side, one for
// the elevation and one for the azimuth, each doing one micro-rotation per
// clock. An item passes through an accept step, the CORDIC iterations, a
// rounding step, two multiply stages and the output write. The block
// takes one item at a time; in_stall is high from after the accept until
// the output write is done. The result sits in an output register, so a
// held result only blocks the next one if it is still untaken when that
// one finishes. Coordinates saturate to +-65535. Program the registers
// only while the block is idle; a new start_azimuth takes effect at the
// next scan start.
module lidar_polar_to_cartesian (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lptc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // sample input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lptc_pkg::RANGE_BITS-1:0]      range_cm,
    input  logic                                 scan_end,
    // point output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_x,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_y,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_z,
    output logic                                 point_last
);

    logic [lptc_pkg::ANGLE_W-1:0] start_azimuth, azimuth_step, elevation_angle;
    lptc_pkg::ctrl_cmd_t          cmd;

    lptc_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start_azimuth   (start_azimuth),
        .azimuth_step    (azimuth_step),
        .elevation_angle (elevation_angle)
    );

    // Sequencer: owns the handshakes and steps the datapath
    lptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lptc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .range_cm        (range_cm),
        .scan_end        (scan_end),
        .start_azimuth   (start_azimuth),
        .azimuth_step    (azimuth_step),
        .elevation_angle (elevation_angle),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .point_last      (point_last)
    );

endmodule

// ===== rtl/core/lptc_cordic.sv =====
// lptc_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle,
// with quadrant fold and Q1.15 rounding/saturation. Depends on lptc_pkg.
module lptc_cordic (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic                                 rotate,
    input  logic                                 round,
    input  logic [lptc_pkg::STEP_W-1:0]          step,
    input  logic [lptc_pkg::ANGLE_W-1:0]         angle,
    output logic signed [lptc_pkg::TRIG_W-1:0]   cos_q15,
    output logic signed [lptc_pkg::TRIG_W-1:0]   sin_q15
);

    logic signed [lptc_pkg::CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic                                 flip_reg;
    logic signed [lptc_pkg::TRIG_W-1:0]   cos_reg, sin_reg;

    logic signed [lptc_pkg::CORDIC_W-1:0] angle_ext, z_load, dx, dy, atan_val;
    logic signed [lptc_pkg::CORDIC_W-1:0] x_rnd, y_rnd;
    logic                                 flip_load;

    function automatic logic signed [lptc_pkg::TRIG_W-1:0] sat_trig(
        input logic signed [lptc_pkg::CORDIC_W-1:0] v);
        logic signed [lptc_pkg::CORDIC_W-1:0] s;
        s = v >>> lptc_pkg::TRIG_SHIFT;
        if (s > lptc_pkg::TRIG_MAX)
            return lptc_pkg::TRIG_MAX[lptc_pkg::TRIG_W-1:0];
        else if (s < lptc_pkg::TRIG_MIN)
            return lptc_pkg::TRIG_MIN[lptc_pkg::TRIG_W-1:0];
        else
            return s[lptc_pkg::TRIG_W-1:0];
    endfunction

    // Fold angles beyond a quarter turn by a half turn; results negate later
    assign angle_ext = lptc_pkg::CORDIC_W'($signed(angle));
    assign flip_load = (angle_ext > lptc_pkg::QUARTER_TURN) ||
                       (angle_ext < -lptc_pkg::QUARTER_TURN);
    assign z_load    = lptc_pkg::CORDIC_W'($signed(angle ^ {flip_load, 31'b0}));

    assign dx       = y_reg >>> step;
    assign dy       = x_reg >>> step;
    assign atan_val = lptc_pkg::CORDIC_W'(
                          lptc_pkg::atan_lut(lptc_pkg::ATAN_IDX_W'(step)));

    assign x_rnd = flip_reg ? lptc_pkg::TRIG_HALF - x_reg : x_reg + lptc_pkg::TRIG_HALF;
    assign y_rnd = flip_reg ? lptc_pkg::TRIG_HALF - y_reg : y_reg + lptc_pkg::TRIG_HALF;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= lptc_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_load;
            flip_reg <= flip_load;
        end
        else if (rotate)
        begin
            if (!z_reg[lptc_pkg::CORDIC_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_val;
            end
        end
        if (round)
        begin
            cos_reg <= sat_trig(x_rnd);
            sin_reg <= sat_trig(y_rnd);
        end
    end

    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;

endmodule

// ===== rtl/core/lptc_regs.sv =====
// lptc_regs: APB-style configuration registers (start azimuth, azimuth
// step, elevation). Depends on lptc_pkg.
module lptc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lptc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [lptc_pkg::ANGLE_W-1:0]      start_azimuth,
    output logic [lptc_pkg::ANGLE_W-1:0]      azimuth_step,
    output logic [lptc_pkg::ANGLE_W-1:0]      elevation_angle
);

    logic [lptc_pkg::ANGLE_W-1:0] start_az_reg, az_step_reg, elev_reg;
    logic                         wr_en;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_az_reg <= '0;
            az_step_reg  <= '0;
            elev_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                lptc_pkg::REG_START_AZIMUTH:   start_az_reg <= pwdata;
                lptc_pkg::REG_AZIMUTH_STEP:    az_step_reg  <= pwdata;
                lptc_pkg::REG_ELEVATION_ANGLE: elev_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            lptc_pkg::REG_START_AZIMUTH:   prdata = start_az_reg;
            lptc_pkg::REG_AZIMUTH_STEP:    prdata = az_step_reg;
            lptc_pkg::REG_ELEVATION_ANGLE: prdata = elev_reg;
            default:                       prdata = '0;
        endcase
    end

    assign start_azimuth   = start_az_reg;
    assign azimuth_step    = az_step_reg;
    assign elevation_angle = elev_reg;

endmodule

// ===== rtl/core/lptc_datapath.sv =====
// lptc_datapath: running azimuth, two CORDIC lanes (elevation, azimuth),
// range scaling multipliers, rounding and output registers.
// Depends on lptc_pkg and lptc_cordic.
module lptc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lptc_pkg::ctrl_cmd_t                  cmd,
    input  logic [lptc_pkg::RANGE_BITS-1:0]      range_cm,
    input  logic                                 scan_end,
    input  logic [lptc_pkg::ANGLE_W-1:0]         start_azimuth,
    input  logic [lptc_pkg::ANGLE_W-1:0]         azimuth_step,
    input  logic [lptc_pkg::ANGLE_W-1:0]         elevation_angle,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_x,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_y,
    output logic signed [lptc_pkg::COORD_W-1:0]  pos_z,
    output logic                                 point_last
);

    // Scan tracking state
    logic [lptc_pkg::ANGLE_W-1:0] azimuth_acc_reg, az_next;
    logic                         at_start_reg;

    // Item payload
    logic [lptc_pkg::RANGE_BITS-1:0] range_reg;
    logic                            last_reg;

    logic signed [lptc_pkg::TRIG_W-1:0]  cos_el, sin_el, cos_az, sin_az;
    logic signed [lptc_pkg::PROD1_W-1:0] d_reg, pz_prod_reg;
    logic signed [lptc_pkg::PROD2_W-1:0] px_prod_reg, py_prod_reg;
    logic signed [lptc_pkg::COORD_W-1:0] pz_reg;
    logic signed [lptc_pkg::COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic                                last_out_reg;
    logic signed [lptc_pkg::RANGE_BITS:0] range_s;

    function automatic logic signed [lptc_pkg::COORD_W-1:0] sat_coord(
        input logic signed [lptc_pkg::PROD2_W-1:0] v);
        if (v > lptc_pkg::COORD_MAX)
            return lptc_pkg::COORD_MAX[lptc_pkg::COORD_W-1:0];
        else if (v < -lptc_pkg::COORD_MAX)
            return -lptc_pkg::COORD_MAX[lptc_pkg::COORD_W-1:0];
        else
            return v[lptc_pkg::COORD_W-1:0];
    endfunction

    assign az_next = at_start_reg ? start_azimuth : azimuth_acc_reg + azimuth_step;
    assign range_s = $signed({1'b0, range_reg});

    lptc_cordic u_cordic_el (
        .clk     (clk),
        .load    (cmd.load),
        .rotate  (cmd.rotate),
        .round   (cmd.round),
        .step    (cmd.step),
        .angle   (elevation_angle),
        .cos_q15 (cos_el),
        .sin_q15 (sin_el)
    );

    lptc_cordic u_cordic_az (
        .clk     (clk),
        .load    (cmd.load),
        .rotate  (cmd.rotate),
        .round   (cmd.round),
        .step    (cmd.step),
        .angle   (az_next),
        .cos_q15 (cos_az),
        .sin_q15 (sin_az)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            azimuth_acc_reg <= '0;
            at_start_reg    <= 1'b1;
        end
        else if (cmd.load)
        begin
            azimuth_acc_reg <= az_next;
            at_start_reg    <= scan_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            range_reg <= range_cm;
            last_reg  <= scan_end;
        end
        if (cmd.mul1)
        begin
            d_reg       <= range_s * cos_el;
            pz_prod_reg <= range_s * sin_el;
        end
        if (cmd.mul2)
        begin
            px_prod_reg <= d_reg * cos_az;
            py_prod_reg <= d_reg * sin_az;
            pz_reg      <= sat_coord((lptc_pkg::PROD2_W'(pz_prod_reg) + lptc_pkg::Z_HALF)
                                     >>> lptc_pkg::Z_SHIFT);
        end
        if (cmd.write)
        begin
            pos_x_reg    <= sat_coord((px_prod_reg + lptc_pkg::XY_HALF) >>> lptc_pkg::XY_SHIFT);
            pos_y_reg    <= sat_coord((py_prod_reg + lptc_pkg::XY_HALF) >>> lptc_pkg::XY_SHIFT);
            pos_z_reg    <= pz_reg;
            last_out_reg <= last_reg;
        end
    end

    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign point_last = last_out_reg;

endmodule

// ===== rtl/core/lptc_ctrl.sv =====
// lptc_ctrl: sequencing state machine for one item (load, CORDIC steps,
// round, two multiply stages, output write) and output valid. Depends on lptc_pkg.
module lptc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lptc_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROT   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    localparam logic [lptc_pkg::STEP_W-1:0] STEP_LAST =
        lptc_pkg::STEP_W'(lptc_pkg::CORDIC_STEPS - 1);

    logic [2:0]                  state_reg, state_next;
    logic [lptc_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        in_acc, do_write;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign do_write = (state_reg == S_WRITE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_ROT;
                    step_next  = '0;
                end
            end
            S_ROT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_ROUND;
            end
            S_ROUND: state_next = S_MUL1;
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_WRITE;
            S_WRITE:
            begin
                if (do_write)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (do_write)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_acc;
    assign cmd.rotate = (state_reg == S_ROT);
    assign cmd.round  = (state_reg == S_ROUND);
    assign cmd.mul1   = (state_reg == S_MUL1);
    assign cmd.mul2   = (state_reg == S_MUL2);
    assign cmd.write  = do_write;
    assign cmd.step   = step_reg;

endmodule

// ===== rtl/core/lptc_checker.sv =====
// lptc_checker: port-level assertions for lidar_polar_to_cartesian and the
// bind that attaches them. Depends on lptc_pkg.
module lptc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [lptc_pkg::COORD_W-1:0]  pos_x,
    input logic signed [lptc_pkg::COORD_W-1:0]  pos_y,
    input logic signed [lptc_pkg::COORD_W-1:0]  pos_z,
    input logic                                 point_last
);

    localparam logic [lptc_pkg::COORD_W-1:0] COORD_BAD = {1'b1, {(lptc_pkg::COORD_W-1){1'b0}}};

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(pos_x) && $stable(pos_y) && $stable(pos_z) && $stable(point_last))
        else $error("stalled result changed");

    // Accepting an item makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("no busy after accept");

    // A new result only appears while an item was in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in flight");

    // Saturation never lets the most negative code through
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pos_x != COORD_BAD) && (pos_y != COORD_BAD) && (pos_z != COORD_BAD))
        else $error("coordinate outside +-65535");

endmodule

bind lidar_polar_to_cartesian lptc_checker u_lptc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .point_last (point_last)
);

// ===== tb/lidar_polar_to_cartesian_tb.sv =====
`timescale 1ns / 1ps
// lidar_polar_to_cartesian_tb: self-checking bench for the polar to Cartesian
// scan converter. Needs lptc_pkg and the lidar_polar_to_cartesian RTL only.
module lidar_polar_to_cartesian_tb;

    localparam int  SETTLE_CYCLES = 40;    // more than one item's latency
    localparam int  STALL_LIMIT   = 4000;  // cycles with no item moving
    localparam int  RAND_PHASES   = 8;
    localparam int  PHASE_ITEMS   = 160;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;  // no register behind it

    // arctangent of 2^-i in binary-angle units, kept apart from the RTL table
    localparam longint ATAN_BAM [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };
    localparam longint GAIN_Q30   = 652032874;
    localparam longint QUARTER    = 64'sd1073741824;
    localparam longint COORD_LIM  = 65535;

    typedef struct packed {
        logic [lptc_pkg::RANGE_BITS-1:0] rng;
        logic                            last;
    } sample_t;

    typedef struct packed {
        logic signed [lptc_pkg::COORD_W-1:0] x;
        logic signed [lptc_pkg::COORD_W-1:0] y;
        logic signed [lptc_pkg::COORD_W-1:0] z;
        logic                                last;
    } point_t;

    // ---------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ---------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [lptc_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                     pwdata  = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [lptc_pkg::RANGE_BITS-1:0] range_cm = '0;
    logic                            scan_end = 1'b0;

    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [lptc_pkg::COORD_W-1:0] pos_x;
    logic signed [lptc_pkg::COORD_W-1:0] pos_y;
    logic signed [lptc_pkg::COORD_W-1:0] pos_z;
    logic                                point_last;

    always #4 clk = ~clk;

    lidar_polar_to_cartesian u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .range_cm   (range_cm),
        .scan_end   (scan_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .point_last (point_last)
    );

    // ---------------------------------------------------------------
    // Bench state: pending samples, expected points, register mirror
    // ---------------------------------------------------------------
    sample_t     sample_q[$];
    point_t      expected_points[$];
    int          error_count   = 0;
    int          send_idle_pct = 0;   // chance per cycle that the sender holds off
    int          recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int          quiet_cycles  = 0;

    logic [31:0] cfg_start_az = '0;
    logic [31:0] cfg_step     = '0;
    logic [31:0] cfg_elev     = '0;
    logic [31:0] azimuth_now  = '0;   // azimuth of the latest sample
    logic        scan_start   = 1'b1; // next sample opens a scan

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Fixed-length CORDIC in rotation mode, Q2.30 vectors, rounded to Q1.15.
    // Angles past a quarter turn are rotated by a half turn and negated after.
    function automatic void cordic_sincos(input logic [31:0] angle,
                                          output longint cos_q15,
                                          output longint sin_q15);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        int     n_steps;
        z       = longint'($signed(angle));
        x       = GAIN_Q30;
        y       = 0;
        flip    = 1'b0;
        n_steps = (lptc_pkg::CORDIC_STEPS > 24) ? 24 : lptc_pkg::CORDIC_STEPS;
        if (z > QUARTER || z < -QUARTER)
        begin
            z    = longint'($signed(angle - 32'h8000_0000));
            flip = 1'b1;
        end
        for (int i = 0; i < n_steps; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_BAM[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_BAM[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        cos_q15 = clamp((x + 16384) >>> 15, -32768, 32767);
        sin_q15 = clamp((y + 16384) >>> 15, -32768, 32767);
    endfunction

    // Advance the running azimuth and work out the point for one sample.
    function automatic point_t predict_point(input logic [lptc_pkg::RANGE_BITS-1:0] rng,
                                             input logic last);
        longint      r;
        longint      ce;
        longint      se;
        longint      ca;
        longint      sa;
        longint      d;
        longint      px;
        longint      py;
        longint      pz;
        logic [31:0] az;
        point_t      p;
        az          = scan_start ? cfg_start_az : azimuth_now + cfg_step;
        azimuth_now = az;
        scan_start  = last;
        cordic_sincos(cfg_elev, ce, se);
        cordic_sincos(az, ca, sa);
        r  = longint'(rng);
        d  = r * ce;
        pz = clamp((r * se + 16384) >>> 15, -COORD_LIM, COORD_LIM);
        px = clamp((d * ca + 64'sd536870912) >>> 30, -COORD_LIM, COORD_LIM);
        py = clamp((d * sa + 64'sd536870912) >>> 30, -COORD_LIM, COORD_LIM);
        p.x    = px[lptc_pkg::COORD_W-1:0];
        p.y    = py[lptc_pkg::COORD_W-1:0];
        p.z    = pz[lptc_pkg::COORD_W-1:0];
        p.last = last;
        return p;
    endfunction

    // ---------------------------------------------------------------
    // Sample driver: presents queued items, holds them while stalled
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t s;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_points = {expected_points, predict_point(range_cm, scan_end)};
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s        = sample_q.pop_front();
                    in_valid <= 1'b1;
                    range_cm <= s.rng;
                    scan_end <= s.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Point monitor: random back-pressure, field-by-field compare
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        point_t p;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    $display("%0t: point with nothing expected, got x=%0d y=%0d z=%0d last=%0b",
                             $time, pos_x, pos_y, pos_z, point_last);
                end
                else
                begin
                    p = expected_points.pop_front();
                    check_field("pos_x", p.x, pos_x);
                    check_field("pos_y", p.y, pos_y);
                    check_field("pos_z", p.z, pos_z);
                    check_field("point_last", p.last, point_last);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Helpers for the sequence below
    // ---------------------------------------------------------------
    // Setup then access cycle; the register takes the data on the access edge.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lptc_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lptc_pkg::REG_START_AZIMUTH:   cfg_start_az = value;
            lptc_pkg::REG_AZIMUTH_STEP:    cfg_step     = value;
            lptc_pkg::REG_ELEVATION_ANGLE: cfg_elev     = value;
            default:                       ;  // unmapped, dropped by the block
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sample_q.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_sample(input sample_t s);
        sample_q = {sample_q, s};
    endtask

    task automatic queue_sample(input logic [lptc_pkg::RANGE_BITS-1:0] rng, input logic last);
        sample_t s;
        s.rng  = rng;
        s.last = last;
        add_sample(s);
    endtask

    // Angles lean on the corners: zero, both quarter turns, half turn, wrap edges.
    function automatic logic [31:0] pick_angle();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h4000_0000;
            4:       return 32'hC000_0000;
            5:       return 32'h4000_0001;
            6:       return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(9))
            0:       s.rng = '0;
            1:       s.rng = '1;
            2:       s.rng = lptc_pkg::RANGE_BITS'($urandom_range(255));
            default: s.rng = lptc_pkg::RANGE_BITS'($urandom);
        endcase
        s.last = ($urandom_range(15) == 0);
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int n_items;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero elevation, so cos saturates just below one.
        queue_sample('0, 1'b0);
        queue_sample('1, 1'b0);
        queue_sample(16'd1, 1'b0);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h5555, 1'b0);
        queue_sample(16'hAAAA, 1'b1);
        wait_drained();

        // Quarter-turn elevation (not folded), half-turn step, plus a write
        // to the unmapped slot that must change nothing.
        write_reg(lptc_pkg::REG_START_AZIMUTH, 32'h7FFF_FFFF);
        write_reg(lptc_pkg::REG_AZIMUTH_STEP, 32'h8000_0000);
        write_reg(lptc_pkg::REG_ELEVATION_ANGLE, 32'h4000_0000);
        write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
        queue_sample('1, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(16'h1234, 1'b0);
        queue_sample('1, 1'b0);
        queue_sample(16'h7FFF, 1'b0);
        wait_drained();

        // Scan is still open: the new start azimuth waits for the next scan.
        // The step is just under a half turn, so the running azimuth wraps past zero.
        write_reg(lptc_pkg::REG_START_AZIMUTH, 32'h8000_0000);
        write_reg(lptc_pkg::REG_AZIMUTH_STEP, 32'h7FFF_FFFF);
        write_reg(lptc_pkg::REG_ELEVATION_ANGLE, 32'hC000_0000);
        queue_sample('1, 1'b0);
        queue_sample('1, 1'b0);
        queue_sample('1, 1'b1);
        queue_sample('1, 1'b0);
        queue_sample('0, 1'b1);
        wait_drained();

        // Half-turn elevation and azimuth: both cosines at the negative limit,
        // largest coordinate magnitude.
        write_reg(lptc_pkg::REG_ELEVATION_ANGLE, 32'h8000_0000);
        write_reg(lptc_pkg::REG_AZIMUTH_STEP, 32'hFFFF_FFFF);
        queue_sample('1, 1'b1);
        queue_sample('1, 1'b0);
        queue_sample(16'hC000, 1'b0);
        queue_sample(16'h3FFF, 1'b1);
        wait_drained();

        // Random phases, cycling through the idle/stall mixes.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            if ($urandom_range(3) != 0)
                write_reg(lptc_pkg::REG_START_AZIMUTH, pick_angle());
            write_reg(lptc_pkg::REG_AZIMUTH_STEP, pick_angle());
            write_reg(lptc_pkg::REG_ELEVATION_ANGLE, pick_angle());
            if ($urandom_range(3) == 0)
                write_reg(REG_UNMAPPED, $urandom);
            n_items = PHASE_ITEMS;
            if (p == 5)
            begin
                // sender holds back until every point so far is out
                for (int k = 0; k < PHASE_ITEMS / 2; k++)
                    add_sample(pick_sample());
                wait_drained();
                n_items = PHASE_ITEMS - PHASE_ITEMS / 2;
            end
            for (int k = 0; k < n_items; k++)
                add_sample(pick_sample());
            wait_drained();
        end

        if (error_count == 0 && expected_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lptc_pkg.sv
rtl/core/lptc_cordic.sv
rtl/core/lptc_regs.sv
rtl/core/lptc_datapath.sv
rtl/core/lptc_ctrl.sv
rtl/core/lidar_polar_to_cartesian.sv
rtl/core/lptc_checker.sv
tb/lidar_polar_to_cartesian_tb.sv
